// ===== sv/trs_pkg.sv =====
// ----------------------------------------------------------------------------
// trs_pkg - shared types and constants for the triangle span rasterizer
// Widths, vertex type, setup job codes, sequencer states and divider links.
// ----------------------------------------------------------------------------
package trs_pkg;

	localparam int COORD_BITS = 12;
	localparam int DEPTH_BITS = 16;
	localparam int FRAC_BITS  = 16;
	// wide enough for every setup numerator and every edge accumulator
	localparam int FIX_BITS   = COORD_BITS + DEPTH_BITS + FRAC_BITS + 4;
	localparam int LEVEL_BITS = 9;
	localparam int COLOR_BITS = 24;
	localparam logic [LEVEL_BITS-1:0] FULL_LEVEL = LEVEL_BITS'(256);

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	typedef logic signed [FIX_BITS-1:0] fix_t;
	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [DEPTH_BITS-1:0] depth_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		depth_t z;
	} vertex_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_ISSUE,
		SEQ_WAIT
	} seq_state_t;

	typedef enum logic [3:0] {
		JOB_SPLIT_X,
		JOB_SPLIT_Z,
		JOB_TOP_XL,
		JOB_TOP_XR,
		JOB_TOP_ZL,
		JOB_TOP_ZR,
		JOB_BOT_XL,
		JOB_BOT_XR,
		JOB_BOT_ZL,
		JOB_BOT_ZR
	} job_t;

	typedef struct packed {
		logic                  start;
		fix_t                  num;
		logic [COORD_BITS-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		fix_t quo;
	} div_rsp_t;

	// truncate a fixed-point value toward zero
	function automatic fix_t fx_trunc(input fix_t a);
		fix_t bias;
		bias = fix_t'((64'd1 << FRAC_BITS) - 64'd1);
		if (a < 0)
			return (a + bias) >>> FRAC_BITS;
		return a >>> FRAC_BITS;
	endfunction

	function automatic fix_t coord_fx(input coord_t v);
		return fix_t'(v) <<< FRAC_BITS;
	endfunction

	function automatic fix_t depth_fx(input depth_t v);
		return fix_t'(v) <<< FRAC_BITS;
	endfunction

endpackage

// ===== sv/trs_div.sv =====
// ----------------------------------------------------------------------------
// trs_div - shared restoring divider
// Signed numerator by positive divisor, one quotient bit per cycle,
// quotient truncated toward zero. done pulses for one cycle.
// ----------------------------------------------------------------------------
module trs_div (
	input  logic              clk,
	input  logic              arst_n,
	input  trs_pkg::div_req_t req,
	output trs_pkg::div_rsp_t rsp
);

	localparam int N = trs_pkg::FIX_BITS;
	localparam int C = trs_pkg::COORD_BITS;
	localparam int CW = $clog2(N + 1);

	logic [N-1:0]  mag_q;
	logic [C-1:0]  rem_q;
	logic [C-1:0]  den_q;
	logic          neg_q;
	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;

	logic [C:0]    trial;
	logic          ge;
	logic [C:0]    diff;

	assign trial = {rem_q, mag_q[N-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(N - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			mag_q <= req.num[N-1] ? N'(-req.num) : N'(req.num);
			neg_q <= req.num[N-1];
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			mag_q <= {mag_q[N-2:0], ge};
			rem_q <= ge ? diff[C-1:0] : trial[C-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = neg_q ? -$signed(mag_q) : $signed(mag_q);

endmodule

// ===== sv/trs_sort.sv =====
// ----------------------------------------------------------------------------
// trs_sort - three-vertex sort by y
// Stable: vertices with equal y keep their input order.
// ----------------------------------------------------------------------------
module trs_sort (
	input  trs_pkg::vertex_t v0,
	input  trs_pkg::vertex_t v1,
	input  trs_pkg::vertex_t v2,
	output trs_pkg::vertex_t s0,
	output trs_pkg::vertex_t s1,
	output trs_pkg::vertex_t s2
);

	trs_pkg::vertex_t a;
	trs_pkg::vertex_t b;

	always_comb begin
		if (v1.y < v0.y) begin
			a = v1;
			b = v0;
		end else begin
			a = v0;
			b = v1;
		end
		if (v2.y < a.y) begin
			s0 = v2;
			s1 = a;
			s2 = b;
		end else if (v2.y < b.y) begin
			s0 = a;
			s1 = v2;
			s2 = b;
		end else begin
			s0 = a;
			s1 = b;
			s2 = v2;
		end
	end

endmodule

// ===== sv/triangle_span_rasterizer.sv =====
// ----------------------------------------------------------------------------
// triangle_span_rasterizer - scanline span generator for one triangle
// Load sorts vertices and sets up edges with a shared divider; steps emit spans.
// ----------------------------------------------------------------------------
// A load transaction works out the split point and the x and z slopes of
// both edges of both halves in turn on a single bit-serial divider, and no
// transaction is taken meanwhile. A degenerate load (all three y equal)
// starts no setup. A step transaction's result sits in the output register;
// a further transaction is taken once that result is taken or in the same cycle.
module triangle_span_rasterizer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                op,
	input  logic signed [trs_pkg::COORD_BITS-1:0] vx0,
	input  logic signed [trs_pkg::COORD_BITS-1:0] vy0,
	input  logic [trs_pkg::DEPTH_BITS-1:0]      vz0,
	input  logic signed [trs_pkg::COORD_BITS-1:0] vx1,
	input  logic signed [trs_pkg::COORD_BITS-1:0] vy1,
	input  logic [trs_pkg::DEPTH_BITS-1:0]      vz1,
	input  logic signed [trs_pkg::COORD_BITS-1:0] vx2,
	input  logic signed [trs_pkg::COORD_BITS-1:0] vy2,
	input  logic [trs_pkg::DEPTH_BITS-1:0]      vz2,
	input  logic [trs_pkg::LEVEL_BITS-1:0]      face_level,
	input  logic [trs_pkg::COLOR_BITS-1:0]      fill_color,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                has_span,
	output logic signed [trs_pkg::COORD_BITS-1:0] row,
	output logic signed [trs_pkg::COORD_BITS-1:0] span_x_left,
	output logic signed [trs_pkg::COORD_BITS-1:0] span_x_right,
	output logic [trs_pkg::DEPTH_BITS-1:0]      span_z_left,
	output logic [trs_pkg::DEPTH_BITS-1:0]      span_z_right,
	output logic [trs_pkg::LEVEL_BITS-1:0]      span_level,
	output logic [trs_pkg::COLOR_BITS-1:0]      span_color,
	output logic                                last_span,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic                                cfg_data
);

	localparam int C = trs_pkg::COORD_BITS;
	localparam int D = trs_pkg::DEPTH_BITS;
	localparam int L = trs_pkg::LEVEL_BITS;

	trs_pkg::seq_state_t state_q, state_d;
	trs_pkg::job_t       job_q;
	trs_pkg::div_req_t   div_req;
	trs_pkg::div_rsp_t   div_rsp;

	trs_pkg::vertex_t    in_v0, in_v1, in_v2;
	trs_pkg::vertex_t    srt0, srt1, srt2;
	trs_pkg::vertex_t    vs0_q, vs1_q, vs2_q;
	trs_pkg::coord_t     sx_q;
	trs_pkg::depth_t     sz_q;
	trs_pkg::fix_t       top_slope_q [4];
	trs_pkg::fix_t       bot_slope_q [4];
	trs_pkg::fix_t       acc_q [4];
	logic signed [C:0]   row_q;
	logic                lower_q;
	logic                active_q;
	logic [L-1:0]        level_q;
	logic [trs_pkg::COLOR_BITS-1:0] color_q;
	logic                mode_q;
	logic                out_valid_q;

	logic                in_accept, load_go, step_go, seq_done, flat_top;
	logic signed [C:0]   dy01, dy02, dy12;
	logic signed [C:0]   dx02;
	logic signed [D:0]   dz02;
	logic [L-1:0]        sat_level;
	trs_pkg::fix_t       bot_start [4];
	trs_pkg::fix_t       eff_acc [4];
	trs_pkg::fix_t       eff_slope [4];
	trs_pkg::fix_t       al, ar, zl, zr;
	logic                switch_half, use_bot, swap, last;

	assign in_v0 = '{x: vx0, y: vy0, z: vz0};
	assign in_v1 = '{x: vx1, y: vy1, z: vz1};
	assign in_v2 = '{x: vx2, y: vy2, z: vz2};

	trs_sort u_sort (
		.v0 (in_v0), .v1 (in_v1), .v2 (in_v2),
		.s0 (srt0),  .s1 (srt1),  .s2 (srt2)
	);

	trs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != trs_pkg::SEQ_IDLE) || (out_valid_q && out_stall);
	assign in_accept = in_valid && !in_stall;
	assign load_go   = in_accept && (op == trs_pkg::OP_LOAD) && (srt2.y != srt0.y);
	assign step_go   = in_accept && (op == trs_pkg::OP_STEP);
	assign out_valid = out_valid_q;

	assign sat_level = (face_level > trs_pkg::FULL_LEVEL) ? trs_pkg::FULL_LEVEL : face_level;

	// setup differences from the sorted vertices
	assign dy01 = (C+1)'(vs1_q.y) - (C+1)'(vs0_q.y);
	assign dy02 = (C+1)'(vs2_q.y) - (C+1)'(vs0_q.y);
	assign dy12 = (C+1)'(vs2_q.y) - (C+1)'(vs1_q.y);
	assign dx02 = (C+1)'(vs2_q.x) - (C+1)'(vs0_q.x);
	assign dz02 = $signed({1'b0, vs2_q.z}) - $signed({1'b0, vs0_q.z});
	assign flat_top = (dy01 == '0);

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			trs_pkg::SEQ_IDLE:  if (load_go) state_d = trs_pkg::SEQ_ISSUE;
			trs_pkg::SEQ_ISSUE: state_d = trs_pkg::SEQ_WAIT;
			trs_pkg::SEQ_WAIT: begin
				if (div_rsp.done)
					state_d = (job_q == trs_pkg::JOB_BOT_ZR) ? trs_pkg::SEQ_IDLE
					                                        : trs_pkg::SEQ_ISSUE;
			end
			default: state_d = trs_pkg::SEQ_IDLE;
		endcase
	end

	assign seq_done = (state_q == trs_pkg::SEQ_WAIT) && div_rsp.done
	                  && (job_q == trs_pkg::JOB_BOT_ZR);

	always_comb begin
		div_req.start = (state_q == trs_pkg::SEQ_ISSUE);
		div_req.num   = '0;
		div_req.den   = dy01[C-1:0];
		case (job_q)
			trs_pkg::JOB_SPLIT_X: begin
				div_req.num = trs_pkg::fix_t'(dy01 * dx02);
				div_req.den = dy02[C-1:0];
			end
			trs_pkg::JOB_SPLIT_Z: begin
				div_req.num = trs_pkg::fix_t'(dy01 * dz02);
				div_req.den = dy02[C-1:0];
			end
			trs_pkg::JOB_TOP_XL: div_req.num = trs_pkg::coord_fx(vs1_q.x) - trs_pkg::coord_fx(vs0_q.x);
			trs_pkg::JOB_TOP_XR: div_req.num = trs_pkg::coord_fx(sx_q) - trs_pkg::coord_fx(vs0_q.x);
			trs_pkg::JOB_TOP_ZL: div_req.num = trs_pkg::depth_fx(vs1_q.z) - trs_pkg::depth_fx(vs0_q.z);
			trs_pkg::JOB_TOP_ZR: div_req.num = trs_pkg::depth_fx(sz_q) - trs_pkg::depth_fx(vs0_q.z);
			trs_pkg::JOB_BOT_XL: begin
				div_req.num = trs_pkg::coord_fx(vs2_q.x) - trs_pkg::coord_fx(vs1_q.x);
				div_req.den = dy12[C-1:0];
			end
			trs_pkg::JOB_BOT_XR: begin
				div_req.num = trs_pkg::coord_fx(vs2_q.x) - trs_pkg::coord_fx(sx_q);
				div_req.den = dy12[C-1:0];
			end
			trs_pkg::JOB_BOT_ZL: begin
				div_req.num = trs_pkg::depth_fx(vs2_q.z) - trs_pkg::depth_fx(vs1_q.z);
				div_req.den = dy12[C-1:0];
			end
			trs_pkg::JOB_BOT_ZR: begin
				div_req.num = trs_pkg::depth_fx(vs2_q.z) - trs_pkg::depth_fx(sz_q);
				div_req.den = dy12[C-1:0];
			end
			default: div_req.num = '0;
		endcase
	end

	// span datapath
	assign bot_start[0] = trs_pkg::coord_fx(vs1_q.x);
	assign bot_start[1] = trs_pkg::coord_fx(sx_q);
	assign bot_start[2] = trs_pkg::depth_fx(vs1_q.z);
	assign bot_start[3] = trs_pkg::depth_fx(sz_q);

	assign switch_half = !lower_q && (row_q >= (C+1)'(vs1_q.y));
	assign use_bot     = lower_q || switch_half;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			eff_acc[k]   = switch_half ? bot_start[k] : acc_q[k];
			eff_slope[k] = use_bot ? bot_slope_q[k] : top_slope_q[k];
		end
	end

	assign swap = eff_acc[0] >= eff_acc[1];
	assign al   = trs_pkg::fx_trunc(swap ? eff_acc[1] : eff_acc[0]);
	assign ar   = trs_pkg::fx_trunc(swap ? eff_acc[0] : eff_acc[1]);
	assign zl   = trs_pkg::fx_trunc(swap ? eff_acc[3] : eff_acc[2]);
	assign zr   = trs_pkg::fx_trunc(swap ? eff_acc[2] : eff_acc[3]);
	assign last = row_q == ((C+1)'(vs2_q.y) - (C+1)'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= trs_pkg::SEQ_IDLE;
			job_q       <= trs_pkg::JOB_SPLIT_X;
			active_q    <= 1'b0;
			lower_q     <= 1'b0;
			mode_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready)
				mode_q <= cfg_data;

			if (in_accept && (op == trs_pkg::OP_LOAD)) begin
				active_q <= 1'b0;
				lower_q  <= 1'b0;
				job_q    <= trs_pkg::JOB_SPLIT_X;
			end else if ((state_q == trs_pkg::SEQ_WAIT) && div_rsp.done && !seq_done) begin
				job_q <= trs_pkg::job_t'(job_q + 4'd1);
			end

			if (seq_done) begin
				active_q <= 1'b1;
				lower_q  <= flat_top;
			end

			if (step_go && active_q) begin
				lower_q <= use_bot;
				if (last)
					active_q <= 1'b0;
			end

			if (step_go)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_accept && (op == trs_pkg::OP_LOAD)) begin
			vs0_q   <= srt0;
			vs1_q   <= srt1;
			vs2_q   <= srt2;
			level_q <= mode_q ? sat_level : trs_pkg::FULL_LEVEL;
			color_q <= fill_color;
		end

		if ((state_q == trs_pkg::SEQ_WAIT) && div_rsp.done) begin
			case (job_q)
				trs_pkg::JOB_SPLIT_X: sx_q <= vs0_q.x + div_rsp.quo[C-1:0];
				trs_pkg::JOB_SPLIT_Z: sz_q <= vs0_q.z + div_rsp.quo[D-1:0];
				trs_pkg::JOB_TOP_XL:  top_slope_q[0] <= div_rsp.quo;
				trs_pkg::JOB_TOP_XR:  top_slope_q[1] <= div_rsp.quo;
				trs_pkg::JOB_TOP_ZL:  top_slope_q[2] <= div_rsp.quo;
				trs_pkg::JOB_TOP_ZR:  top_slope_q[3] <= div_rsp.quo;
				trs_pkg::JOB_BOT_XL:  bot_slope_q[0] <= div_rsp.quo;
				trs_pkg::JOB_BOT_XR:  bot_slope_q[1] <= div_rsp.quo;
				trs_pkg::JOB_BOT_ZL:  bot_slope_q[2] <= div_rsp.quo;
				trs_pkg::JOB_BOT_ZR:  bot_slope_q[3] <= div_rsp.quo;
				default: ;
			endcase
		end

		if (seq_done) begin
			// flat top starts straight on the bottom half
			if (flat_top) begin
				row_q <= (C+1)'(vs1_q.y);
				for (int k = 0; k < 4; k++)
					acc_q[k] <= bot_start[k];
			end else begin
				row_q    <= (C+1)'(vs0_q.y);
				acc_q[0] <= trs_pkg::coord_fx(vs0_q.x);
				acc_q[1] <= trs_pkg::coord_fx(vs0_q.x);
				acc_q[2] <= trs_pkg::depth_fx(vs0_q.z);
				acc_q[3] <= trs_pkg::depth_fx(vs0_q.z);
			end
		end

		if (step_go) begin
			if (active_q) begin
				has_span     <= 1'b1;
				row          <= row_q[C-1:0];
				span_x_left  <= al[C-1:0];
				span_x_right <= ar[C-1:0];
				span_z_left  <= zl[D-1:0];
				span_z_right <= zr[D-1:0];
				span_level   <= level_q;
				span_color   <= color_q;
				last_span    <= last;
				for (int k = 0; k < 4; k++)
					acc_q[k] <= eff_acc[k] + eff_slope[k];
				row_q <= row_q + (C+1)'(1);
			end else begin
				has_span     <= 1'b0;
				row          <= '0;
				span_x_left  <= '0;
				span_x_right <= '0;
				span_z_left  <= '0;
				span_z_right <= '0;
				span_level   <= '0;
				span_color   <= '0;
				last_span    <= 1'b0;
			end
		end
	end

endmodule
